// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL files; only the top level includes them.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/smpg_pkg.sv =====
`timescale 1ns / 1ps
package smpg_pkg;

	localparam int POS_BITS      = 24;
	localparam int COUNT_BITS    = 24;
	localparam int RATE_IN_BITS  = 17;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 24;

	localparam int DEF_TICKS_PER_SECOND = 1000000;
	localparam int DEF_MAX_RATE         = 50000;

	localparam logic signed [POS_BITS-1:0] POS_RESET     = POS_BITS'(1);
	localparam logic signed [POS_BITS-1:0] POS_MIN_RESET = POS_BITS'(0);
	localparam logic signed [POS_BITS-1:0] POS_MAX_RESET = POS_BITS'(220 * 80);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_POSITION_MIN = 1'b0,
		REG_POSITION_MAX = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic tick_upd;   // apply one tick and load the result register
		logic res_now;    // load the result register for a command that starts nothing
		logic div_start;  // latch a new move and prepare the divider
		logic div_step;   // one quotient bit
		logic div_finish; // commit the half period and load the result register
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic moving;
		logic steps_zero;
		logic div_last;
	} sts_t;

endpackage

// ===== hdl/smpg_req_if.sv =====
`timescale 1ns / 1ps
interface smpg_req_if;
	import smpg_pkg::*;

	logic                           valid;
	logic                           ready;
	logic                           req_type;
	logic signed [COUNT_BITS-1:0]   step_count;
	logic signed [RATE_IN_BITS-1:0] step_rate;

	modport source (output valid, output req_type, output step_count, output step_rate,
		input ready);
	modport sink (input valid, input req_type, input step_count, input step_rate,
		output ready);
endinterface

// ===== hdl/smpg_res_if.sv =====
`timescale 1ns / 1ps
interface smpg_res_if;
	import smpg_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       step_out;
	logic                       dir_out;
	logic                       busy_res;
	logic                       done_res;
	logic                       limit_hit;
	logic signed [POS_BITS-1:0] position;

	modport source (output valid, output step_out, output dir_out, output busy_res,
		output done_res, output limit_hit, output position, input ready);
	modport sink (input valid, input step_out, input dir_out, input busy_res,
		input done_res, input limit_hit, input position, output ready);
endinterface

// ===== hdl/stepper_move_pulse_generator_top.sv =====
`timescale 1ns / 1ps
// Stepper move pulse generator with soft position limits.
// The req channel carries one item per transfer: a one-microsecond tick
// (req_type 0) or a move command (req_type 1) with a signed step count and a
// speed in steps per second. Every transfer on req produces exactly one
// transfer on res, which reports the step and direction line levels, busy,
// done, limit stop and the position as they stand after that item.
// A tick, or a command that is ignored while busy or has zero steps, is
// answered in the cycle after its transfer. A command that starts a move runs a
// restoring divider of the tick rate by the clamped speed, one quotient bit
// per cycle; the result register is loaded once the divide is done and the
// held result has left. One item is in work at a time. The result register
// decouples the two sides: req is ready again as soon as the held result
// leaves or is being taken in the same cycle; while res is stalled, ready on
// req stays low and no new item is taken.
// The soft limits are written through cfg_we/cfg_index/cfg_data and should
// only be changed while no move is running. Reset leaves the block idle at
// position 1, forward direction, limits 0 and 17600, with no result pending.
`include "assert_macros.svh"
module stepper_move_pulse_generator_top #(
	parameter int TICKS_PER_SECOND = smpg_pkg::DEF_TICKS_PER_SECOND,
	parameter int MAX_RATE         = smpg_pkg::DEF_MAX_RATE
) (
	input  logic                               clk,
	input  logic                               arst_n,
	smpg_req_if.sink                           req,
	smpg_res_if.source                         res,
	input  logic                               cfg_we,
	input  logic [smpg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [smpg_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import smpg_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// The controller sequences transfers and the divider; the datapath holds
	// the move state, the limits, the divider and the result register.
	smpg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (req.ready),
		.out_valid   (res.valid),
		.out_ready   (res.ready),
		.sts         (sts),
		.ctl         (ctl)
	);

	smpg_datapath #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND),
		.MAX_RATE         (MAX_RATE)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.step_count (req.step_count),
		.step_rate  (req.step_rate),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.step_out   (res.step_out),
		.dir_out    (res.dir_out),
		.busy_res   (res.busy_res),
		.done_res   (res.done_res),
		.limit_hit  (res.limit_hit),
		.position   (res.position)
	);

	// A finished move is never reported as still busy.
	`ASSERT_SAME(a_done_not_busy, res.valid && res.done_res, !res.busy_res, "done while busy")
	// A limit stop ends the move with the step line low.
	`ASSERT_SAME(a_hit_stops, res.valid && res.limit_hit, res.done_res && !res.step_out,
		"limit stop without done or with line high")
	// The step line is only driven high during a move.
	`ASSERT_SAME(a_step_busy, res.valid && res.step_out, res.busy_res, "step high while idle")
	// Starting a divide blocks further transfers on req for the next cycle.
	`ASSERT_NEXT(a_div_blocks, ctl.div_start, !req.ready, "req ready during divide")
endmodule

// ===== hdl/smpg_ctrl.sv =====
`timescale 1ns / 1ps
module smpg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_req_type,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  smpg_pkg::sts_t sts,
	output smpg_pkg::ctl_t ctl
);
	import smpg_pkg::*;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;
	logic   starts_move;

	assign out_free    = !out_valid_q || out_ready;
	assign accept      = in_valid && in_ready;
	assign starts_move = in_req_type && !sts.moving && !sts.steps_zero;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && starts_move) state_n = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (sts.div_last) state_n = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = out_free;
				ctl.tick_upd   = accept && !in_req_type;
				ctl.res_now    = accept && in_req_type && !starts_move;
				ctl.div_start  = accept && starts_move;
			end
			ST_DIVIDE: begin
				ctl.div_step = 1'b1;
			end
			ST_FINISH: begin
				ctl.div_finish = out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.tick_upd || ctl.res_now || ctl.div_finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ===== hdl/smpg_datapath.sv =====
`timescale 1ns / 1ps
module smpg_datapath #(
	parameter int TICKS_PER_SECOND = smpg_pkg::DEF_TICKS_PER_SECOND,
	parameter int MAX_RATE         = smpg_pkg::DEF_MAX_RATE
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  smpg_pkg::ctl_t                           ctl,
	output smpg_pkg::sts_t                           sts,
	input  logic signed [smpg_pkg::COUNT_BITS-1:0]   step_count,
	input  logic signed [smpg_pkg::RATE_IN_BITS-1:0] step_rate,
	input  logic                                     cfg_we,
	input  logic [smpg_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [smpg_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	output logic                                     step_out,
	output logic                                     dir_out,
	output logic                                     busy_res,
	output logic                                     done_res,
	output logic                                     limit_hit,
	output logic signed [smpg_pkg::POS_BITS-1:0]     position
);
	import smpg_pkg::*;

	localparam int HP_BITS   = $clog2(TICKS_PER_SECOND + 1);
	localparam int RATE_BITS = $clog2(MAX_RATE + 1);
	localparam int IDX_BITS  = $clog2(HP_BITS);
	localparam logic [HP_BITS-1:0]   TPS_VEC  = HP_BITS'(TICKS_PER_SECOND);
	localparam logic [RATE_BITS-1:0] RATE_TOP = RATE_BITS'(MAX_RATE);

	// Limits and move state.
	logic signed [POS_BITS-1:0] pos_min_q, pos_max_q, position_q;
	logic [COUNT_BITS-1:0]      steps_left_q;
	logic [HP_BITS-1:0]         half_period_q, tick_count_q;
	logic                       moving_q, phase_q, dir_q;

	// Divider.
	logic [RATE_BITS-1:0] divisor_q, rem_q;
	logic [HP_BITS-1:0]   quot_q;
	logic [IDX_BITS-1:0]  bit_idx_q;

	// Result register.
	logic                       res_step_q, res_dir_q, res_busy_q, res_done_q, res_hit_q;
	logic signed [POS_BITS-1:0] res_pos_q;

	// Tick next state.
	logic signed [POS_BITS-1:0] n_position, pos_adv;
	logic [COUNT_BITS-1:0]      n_steps_left, steps_dec;
	logic [HP_BITS-1:0]         n_tick_count, tick_dec;
	logic [HP_BITS:0]           tick_inc;
	logic                       n_moving, n_phase, t_done, t_hit;
	logic                       limit_now, limit_adv;

	// Command decode.
	logic [RATE_IN_BITS-2:0] rate_pos;
	logic [RATE_BITS-1:0]    rate_clamped;
	logic [COUNT_BITS-1:0]   steps_abs;
	logic [RATE_BITS:0]      trial;
	logic                    q_bit;

	assign pos_adv   = dir_q ? position_q - POS_BITS'(1) : position_q + POS_BITS'(1);
	assign steps_dec = steps_left_q - COUNT_BITS'(1);
	assign tick_inc  = {1'b0, tick_count_q} + (HP_BITS + 1)'(1);
	assign tick_dec  = tick_count_q - HP_BITS'(1);
	assign limit_now = (!dir_q && position_q >= pos_max_q) || (dir_q && position_q <= pos_min_q);
	assign limit_adv = (!dir_q && pos_adv >= pos_max_q) || (dir_q && pos_adv <= pos_min_q);

	always_comb begin
		n_position   = position_q;
		n_steps_left = steps_left_q;
		n_tick_count = tick_count_q;
		n_moving     = moving_q;
		n_phase      = phase_q;
		t_done       = 1'b0;
		t_hit        = 1'b0;
		if (moving_q) begin
			if (!phase_q && tick_count_q == '0) begin
				// Start of a step: check the limit, then raise the line.
				n_tick_count = '0;
				if (limit_now) begin
					n_moving     = 1'b0;
					n_steps_left = '0;
					t_done       = 1'b1;
					t_hit        = 1'b1;
				end else begin
					n_phase = 1'b1;
				end
			end else if (phase_q) begin
				if (tick_inc >= {1'b0, half_period_q}) begin
					n_phase      = 1'b0;
					n_tick_count = half_period_q;
				end else begin
					n_tick_count = tick_inc[HP_BITS-1:0];
				end
			end else begin
				n_tick_count = tick_dec;
				if (tick_dec == '0) begin
					// End of the low half: the step is complete.
					n_position   = pos_adv;
					n_steps_left = steps_dec;
					if (steps_dec == '0) begin
						n_moving = 1'b0;
						t_done   = 1'b1;
					end else if (limit_adv) begin
						n_moving     = 1'b0;
						n_steps_left = '0;
						t_done       = 1'b1;
						t_hit        = 1'b1;
					end else begin
						n_phase = 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		rate_pos = step_rate[RATE_IN_BITS-2:0];
		if (step_rate[RATE_IN_BITS-1] || rate_pos == '0) begin
			rate_clamped = RATE_BITS'(1);
		end else if (rate_pos > (RATE_IN_BITS - 1)'(MAX_RATE)) begin
			rate_clamped = RATE_TOP;
		end else begin
			rate_clamped = RATE_BITS'(rate_pos);
		end
		steps_abs = step_count[COUNT_BITS-1] ? COUNT_BITS'(-step_count) : COUNT_BITS'(step_count);
		trial     = {rem_q, TPS_VEC[bit_idx_q]};
		q_bit     = trial >= {1'b0, divisor_q};
	end

	assign sts.moving     = moving_q;
	assign sts.steps_zero = step_count == '0;
	assign sts.div_last   = bit_idx_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_min_q     <= POS_MIN_RESET;
			pos_max_q     <= POS_MAX_RESET;
			position_q    <= POS_RESET;
			steps_left_q  <= '0;
			half_period_q <= '0;
			tick_count_q  <= '0;
			moving_q      <= 1'b0;
			phase_q       <= 1'b0;
			dir_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_POSITION_MIN: pos_min_q <= POS_BITS'(cfg_data);
					REG_POSITION_MAX: pos_max_q <= POS_BITS'(cfg_data);
				endcase
			end
			if (ctl.tick_upd) begin
				position_q   <= n_position;
				steps_left_q <= n_steps_left;
				tick_count_q <= n_tick_count;
				moving_q     <= n_moving;
				phase_q      <= n_phase;
			end
			if (ctl.div_start) begin
				dir_q        <= step_count[COUNT_BITS-1];
				steps_left_q <= steps_abs;
			end
			if (ctl.div_finish) begin
				half_period_q <= (quot_q == '0) ? HP_BITS'(1) : quot_q;
				tick_count_q  <= '0;
				phase_q       <= 1'b0;
				moving_q      <= 1'b1;
			end
		end
	end

	// Restoring divider of the tick rate by the speed, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			divisor_q <= rate_clamped;
			rem_q     <= '0;
			quot_q    <= '0;
			bit_idx_q <= IDX_BITS'(HP_BITS - 1);
		end else if (ctl.div_step) begin
			rem_q     <= q_bit ? RATE_BITS'(trial - {1'b0, divisor_q}) : trial[RATE_BITS-1:0];
			quot_q    <= {quot_q[HP_BITS-2:0], q_bit};
			bit_idx_q <= bit_idx_q - IDX_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tick_upd) begin
			res_step_q <= n_phase;
			res_dir_q  <= dir_q;
			res_busy_q <= n_moving;
			res_done_q <= t_done;
			res_hit_q  <= t_hit;
			res_pos_q  <= n_position;
		end else if (ctl.res_now) begin
			res_step_q <= phase_q;
			res_dir_q  <= dir_q;
			res_busy_q <= moving_q;
			res_done_q <= !moving_q && sts.steps_zero;
			res_hit_q  <= 1'b0;
			res_pos_q  <= position_q;
		end else if (ctl.div_finish) begin
			res_step_q <= 1'b0;
			res_dir_q  <= dir_q;
			res_busy_q <= 1'b1;
			res_done_q <= 1'b0;
			res_hit_q  <= 1'b0;
			res_pos_q  <= position_q;
		end
	end

	assign step_out  = res_step_q;
	assign dir_out   = res_dir_q;
	assign busy_res  = res_busy_q;
	assign done_res  = res_done_q;
	assign limit_hit = res_hit_q;
	assign position  = res_pos_q;
endmodule
